// ===== rtl/hcmm_pkg.sv =====
// ---------------------------------------------------------------------------
// hcmm_pkg
// Shared types, region codes and I/O register tables for the memory map.
// ---------------------------------------------------------------------------
package hcmm_pkg;

   localparam int RomBytes       = 32768;
   localparam int VideoRamBytes  = 8192;
   localparam int SpriteRamBytes = 160;
   localparam int HighRamBytes   = 127;

   typedef enum logic [3:0] {
      RGN_ROM   = 4'd0,
      RGN_VRAM  = 4'd1,
      RGN_CRAM  = 4'd2,
      RGN_WRAM  = 4'd3,
      RGN_OAM   = 4'd4,
      RGN_GAP   = 4'd5,
      RGN_IO    = 4'd6,
      RGN_HRAM  = 4'd7,
      RGN_IE    = 4'd8
   } region_type;

   // classified access handed from front to back
   typedef struct packed {
      logic       write;
      region_type region;
      logic [14:0] offset;
      logic [7:0]  data;
   } access_type;

   localparam int AccessBits = $bits(access_type);

   // I/O offsets with special handling
   localparam logic [6:0] IO_P1   = 7'h00;
   localparam logic [6:0] IO_SC   = 7'h02;
   localparam logic [6:0] IO_DIV  = 7'h04;
   localparam logic [6:0] IO_TAC  = 7'h07;
   localparam logic [6:0] IO_IF   = 7'h0F;
   localparam logic [6:0] IO_STAT = 7'h41;
   localparam logic [6:0] IO_LY   = 7'h44;
   localparam logic [6:0] IO_OBP0 = 7'h48;
   localparam logic [6:0] IO_OBP1 = 7'h49;

   function automatic logic io_known(input logic [6:0] r);
      logic k;
      begin
         unique case (r)
            7'h00, 7'h01, 7'h02, 7'h04, 7'h05, 7'h06, 7'h07, 7'h0F,
            7'h10, 7'h11, 7'h12, 7'h13, 7'h14, 7'h16, 7'h17, 7'h18, 7'h19,
            7'h1A, 7'h1B, 7'h1C, 7'h1D, 7'h1E,
            7'h20, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
            7'h40, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
            7'h48, 7'h49, 7'h4A, 7'h4B: k = 1'b1;
            default: k = 1'b0;
         endcase
         return k;
      end
   endfunction

   function automatic logic [7:0] io_reset_value(input logic [6:0] r);
      logic [7:0] v;
      begin
         unique case (r)
            7'h00: v = 8'hCF;  7'h02: v = 8'h7E;  7'h04: v = 8'hAB;
            7'h07: v = 8'hF8;  7'h0F: v = 8'hE1;  7'h10: v = 8'h80;
            7'h11: v = 8'hBF;  7'h12: v = 8'hF3;  7'h13: v = 8'hFF;
            7'h14: v = 8'hBF;  7'h16: v = 8'h3F;  7'h18: v = 8'hFF;
            7'h19: v = 8'hBF;  7'h1A: v = 8'h7F;  7'h1B: v = 8'hFF;
            7'h1C: v = 8'h9F;  7'h1D: v = 8'hFF;  7'h1E: v = 8'hBF;
            7'h20: v = 8'hFF;  7'h23: v = 8'hBF;  7'h24: v = 8'h77;
            7'h25: v = 8'hF3;  7'h26: v = 8'hF1;  7'h40: v = 8'h91;
            7'h41: v = 8'h85;  7'h46: v = 8'hFF;  7'h47: v = 8'hFC;
            default: v = 8'h00;
         endcase
         return v;
      end
   endfunction

endpackage

// ===== rtl/handheld_console_memory_map_top.sv =====
// ---------------------------------------------------------------------------
// handheld_console_memory_map_top
// Bus memory map: one read or write access in, one result word out.
// ---------------------------------------------------------------------------
// Each access word yields one result word. The front decodes and queues up to
// two accesses; the back handles one access at a time (memory read register,
// then result register) and takes no new one while the read register is full.
// No clearing pass after reset; memories are undefined until written.
module handheld_console_memory_map_top #(
   parameter int ROM_BYTES        = hcmm_pkg::RomBytes,
   parameter int VIDEO_RAM_BYTES  = hcmm_pkg::VideoRamBytes,
   parameter int SPRITE_RAM_BYTES = hcmm_pkg::SpriteRamBytes,
   parameter int HIGH_RAM_BYTES   = hcmm_pkg::HighRamBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] address, [23:16] write_data
   input  logic        req_tuser,   // action: 1 = write
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] read_data
   output logic        rsp_tuser    // unknown_register
);
   import hcmm_pkg::*;

   logic       q_valid, q_ready;
   access_type q_access;

   hcmm_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .q_valid, .q_ready, .q_access
   );

   hcmm_back #(
      .ROM_BYTES(ROM_BYTES), .VIDEO_RAM_BYTES(VIDEO_RAM_BYTES),
      .SPRITE_RAM_BYTES(SPRITE_RAM_BYTES), .HIGH_RAM_BYTES(HIGH_RAM_BYTES)
   ) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_access,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

endmodule

// ===== rtl/hcmm_front.sv =====
// ---------------------------------------------------------------------------
// hcmm_front
// Accepts bus accesses and decodes the address into a region and offset.
// ---------------------------------------------------------------------------
module hcmm_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,
   input  logic                 req_tuser,
   output logic                 q_valid,
   input  logic                 q_ready,
   output hcmm_pkg::access_type q_access
);
   import hcmm_pkg::*;

   logic [15:0] a;
   access_type  cls;
   access_type  q_data_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic        push, pop;

   assign a = req_tdata[15:0];

   always_comb begin
      cls.write  = req_tuser;
      cls.data   = req_tdata[23:16];
      cls.offset = a[14:0];
      priority if (a < 16'h8000) begin
         cls.region = RGN_ROM;
      end else if (a < 16'hA000) begin
         cls.region = RGN_VRAM;
         cls.offset = {2'b0, a[12:0]};
      end else if (a < 16'hC000) begin
         cls.region = RGN_CRAM;
         cls.offset = {2'b0, a[12:0]};
      end else if (a < 16'hFE00) begin
         // work RAM and its echo share the low 13 bits
         cls.region = RGN_WRAM;
         cls.offset = {2'b0, a[12:0]};
      end else if (a < 16'hFEA0) begin
         cls.region = RGN_OAM;
         cls.offset = {7'b0, a[7:0]};
      end else if (a < 16'hFF00) begin
         cls.region = RGN_GAP;
      end else if (a < 16'hFF80) begin
         cls.region = RGN_IO;
         cls.offset = {8'b0, a[6:0]};
      end else if (a < 16'hFFFF) begin
         cls.region = RGN_HRAM;
         cls.offset = {8'b0, a[6:0]};
      end else begin
         cls.region = RGN_IE;
      end
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_access   = q_data_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (push) q_data_ff[wp_ff] <= cls;
   end

endmodule

// ===== rtl/hcmm_back.sv =====
// ---------------------------------------------------------------------------
// hcmm_back
// Carries out decoded accesses on the memories and I/O registers.
// ---------------------------------------------------------------------------
module hcmm_back #(
   parameter int ROM_BYTES        = hcmm_pkg::RomBytes,
   parameter int VIDEO_RAM_BYTES  = hcmm_pkg::VideoRamBytes,
   parameter int SPRITE_RAM_BYTES = hcmm_pkg::SpriteRamBytes,
   parameter int HIGH_RAM_BYTES   = hcmm_pkg::HighRamBytes
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  hcmm_pkg::access_type q_access,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tuser
);
   import hcmm_pkg::*;

   localparam int RomAw = $clog2(ROM_BYTES);
   localparam int VrAw  = $clog2(VIDEO_RAM_BYTES);
   localparam int OamAw = $clog2(SPRITE_RAM_BYTES);
   localparam int HrAw  = $clog2(HIGH_RAM_BYTES);

   logic [7:0] rom_mem  [ROM_BYTES];
   logic [7:0] vram_mem [VIDEO_RAM_BYTES];
   logic [7:0] cram_mem [8192];
   logic [7:0] wram_mem [8192];
   logic [7:0] oam_mem  [SPRITE_RAM_BYTES];
   logic [7:0] hram_mem [HIGH_RAM_BYTES];
   logic [7:0] io_ff    [128];
   logic [7:0] ie_ff;

   // stage 1: memory read issued, result formed in stage 2
   logic       s1_valid_ff;
   access_type s1_ff;
   logic [7:0] rom_rd_ff, vram_rd_ff, cram_rd_ff, wram_rd_ff, oam_rd_ff, hram_rd_ff;
   logic [7:0] io_rd_ff, ie_rd_ff;
   logic       out_valid_ff;
   logic [7:0] out_data_ff;
   logic       out_unk_ff;
   logic       adv, take;
   logic [6:0] r;
   logic [7:0] io_cur, io_new;
   logic       s1_unk;
   logic [7:0] s1_rd;

   // one access in flight at a time keeps I/O read-modify-write simple
   assign take    = !s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign q_ready = take;
   assign adv     = s1_valid_ff;
   assign r       = q_access.offset[6:0];
   assign io_cur  = io_ff[r];

   always_comb begin
      io_new = io_cur;
      unique case (r)
         IO_P1:            io_new = (io_cur & 8'h0F) | (q_access.data & 8'h30);
         IO_SC:            io_new = q_access.data & 8'h81;
         IO_DIV:           io_new = 8'h00;
         IO_TAC:           io_new = q_access.data & 8'h07;
         IO_IF:            io_new = q_access.data & 8'h1F;
         IO_STAT:          io_new = (q_access.data & 8'h78) | (io_cur & 8'h07);
         IO_LY:            io_new = io_cur;
         IO_OBP0, IO_OBP1: io_new = q_access.data & 8'hFC;
         default:          io_new = q_access.data;
      endcase
   end

   always_ff @(posedge clock) begin
      if (take && q_valid) begin
         s1_ff <= q_access;
         if (q_access.write) begin
            unique case (q_access.region)
               RGN_ROM:  rom_mem[q_access.offset[RomAw-1:0]] <= q_access.data;
               RGN_VRAM: vram_mem[q_access.offset[VrAw-1:0]] <= q_access.data;
               RGN_CRAM: cram_mem[q_access.offset[12:0]] <= q_access.data;
               RGN_WRAM: wram_mem[q_access.offset[12:0]] <= q_access.data;
               RGN_OAM:  oam_mem[q_access.offset[OamAw-1:0]] <= q_access.data;
               RGN_HRAM: hram_mem[q_access.offset[HrAw-1:0]] <= q_access.data;
               default: ;
            endcase
         end else begin
            rom_rd_ff  <= rom_mem[q_access.offset[RomAw-1:0]];
            vram_rd_ff <= vram_mem[q_access.offset[VrAw-1:0]];
            cram_rd_ff <= cram_mem[q_access.offset[12:0]];
            wram_rd_ff <= wram_mem[q_access.offset[12:0]];
            oam_rd_ff  <= oam_mem[q_access.offset[OamAw-1:0]];
            hram_rd_ff <= hram_mem[q_access.offset[HrAw-1:0]];
         end
         io_rd_ff <= io_cur;
         ie_rd_ff <= ie_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 128; i++) io_ff[i] <= io_reset_value(7'(i));
         ie_ff <= 8'h00;
      end else if (take && q_valid && q_access.write) begin
         if (q_access.region == RGN_IO && io_known(r)) io_ff[r] <= io_new;
         if (q_access.region == RGN_IE) ie_ff <= q_access.data;
      end
   end

   always_comb begin
      s1_unk = 1'b0;
      s1_rd  = 8'hFF;
      unique case (s1_ff.region)
         RGN_ROM:  s1_rd = rom_rd_ff;
         RGN_VRAM: s1_rd = vram_rd_ff;
         RGN_CRAM: s1_rd = cram_rd_ff;
         RGN_WRAM: s1_rd = wram_rd_ff;
         RGN_OAM:  s1_rd = oam_rd_ff;
         RGN_HRAM: s1_rd = hram_rd_ff;
         RGN_IE:   s1_rd = ie_rd_ff;
         RGN_IO: begin
            s1_unk = !io_known(s1_ff.offset[6:0]);
            unique case (s1_ff.offset[6:0])
               IO_P1:   s1_rd = io_rd_ff | 8'hC0;
               IO_SC:   s1_rd = io_rd_ff | 8'h7E;
               IO_STAT: s1_rd = io_rd_ff | 8'h80;
               IO_LY:   s1_rd = 8'h00;
               7'h13, 7'h18, 7'h1B, 7'h1D, 7'h20: s1_rd = 8'hFF;
               default: s1_rd = s1_unk ? 8'hFF : io_rd_ff;
            endcase
         end
         default:  s1_rd = 8'hFF;
      endcase
      if (s1_ff.write) s1_rd = 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= take && q_valid;
         if (adv) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
      if (adv) begin
         out_data_ff <= s1_rd;
         out_unk_ff  <= s1_unk;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_unk_ff;

endmodule

// ===== rtl/hcmm_checker.sv =====
// ---------------------------------------------------------------------------
// hcmm_checker
// Port-level checks on the memory map block.
// ---------------------------------------------------------------------------
module hcmm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word right after reset");

   a_unk_reads_ff: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata != 8'hFF |-> rsp_tdata == 8'h00)
      else $error("unknown register result not 0xFF or write zero");

   // queue is empty coming out of reset
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_tready)
      else $error("input not ready right after reset");

endmodule

bind handheld_console_memory_map_top hcmm_checker u_checker (.*);

// ===== bench/tb_handheld_console_memory_map_top.sv =====
// ---------------------------------------------------------------------------
// tb_handheld_console_memory_map_top
// Drives random bus accesses and checks each result against a shadow memory.
// ---------------------------------------------------------------------------
// Reads only touch store bytes that were written earlier, so the shadow
// tracks which bytes are valid. I/O, the gap, LY and IE are always readable.
module tb_handheld_console_memory_map_top;
   import hcmm_pkg::*;

   class bus_shadow;
      logic [7:0] mem [int];    // store bytes keyed by flat index
      logic [7:0] io_reg [128];
      logic [7:0] ie_reg;
      logic [7:0] exp_data [$];
      logic       exp_unk [$];
      int         errors;

      function void power_up();
         for (int i = 0; i < 128; i++) io_reg[i] = io_reset_value(7'(i));
         ie_reg = 8'h00;
      endfunction

      // flat store index; -1 for I/O, gap and IE
      function int store_index(logic [15:0] a);
         if (a < 16'hE000) return int'(a);
         if (a < 16'hFE00) return int'(a) - 'h2000;
         if (a < 16'hFEA0) return int'(a);
         if (a >= 16'hFF80 && a != 16'hFFFF) return int'(a);
         return -1;
      endfunction

      function void note_access(logic wr, logic [15:0] a, logic [7:0] d);
         logic [7:0] rd;
         logic       unk;
         logic [6:0] r;
         int         k;
         rd = 8'h00;
         unk = 1'b0;
         r = a[6:0];
         k = store_index(a);
         if (k >= 0) begin
            if (wr) mem[k] = d;
            else rd = mem[k];
         end else if (a == 16'hFFFF) begin
            if (wr) ie_reg = d;
            else rd = ie_reg;
         end else if (a < 16'hFF00) begin
            rd = 8'hFF;
         end else if (!io_known(r)) begin
            rd = 8'hFF;
            unk = 1'b1;
         end else if (wr) begin
            case (r)
               IO_P1:   io_reg[r] = (io_reg[r] & 8'h0F) | (d & 8'h30);
               IO_SC:   io_reg[r] = d & 8'h81;
               IO_DIV:  io_reg[r] = 8'h00;
               IO_TAC:  io_reg[r] = d & 8'h07;
               IO_IF:   io_reg[r] = d & 8'h1F;
               IO_STAT: io_reg[r] = (d & 8'h78) | (io_reg[r] & 8'h07);
               IO_LY:   ;
               IO_OBP0, IO_OBP1: io_reg[r] = d & 8'hFC;
               default: io_reg[r] = d;
            endcase
         end else begin
            case (r)
               IO_P1:   rd = io_reg[r] | 8'hC0;
               IO_SC:   rd = io_reg[r] | 8'h7E;
               IO_STAT: rd = io_reg[r] | 8'h80;
               IO_LY:   rd = 8'h00;
               7'h13, 7'h18, 7'h1B, 7'h1D, 7'h20: rd = 8'hFF;
               default: rd = io_reg[r];
            endcase
         end
         if (wr) rd = 8'h00;
         exp_data.push_back(rd);
         exp_unk.push_back(unk);
      endfunction

      function void check_result(logic [7:0] rd, logic unk);
         logic [7:0] ed;
         logic       eu;
         if (exp_data.size() == 0) begin
            $display("%0t: unexpected word data=%h unk=%b", $time, rd, unk);
            errors++;
            return;
         end
         ed = exp_data.pop_front();
         eu = exp_unk.pop_front();
         if (rd !== ed) begin
            $display("%0t: read_data expected %h actual %h", $time, ed, rd);
            errors++;
         end
         if (unk !== eu) begin
            $display("%0t: unknown_register expected %b actual %b", $time, eu, unk);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [15:0] address, [23:16] write_data
   logic        req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] read_data
   logic        rsp_tuser;   // unknown_register

   bus_shadow shadow;
   int        send_idle_pct;
   int        recv_stall_pct;
   int        hold_off_cycles;
   logic [15:0] written_addr [$];

   handheld_console_memory_map_top DUT (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("tb_handheld_console_memory_map_top: errors");
      $finish;
   end

   // receiver: random stalls plus a counted hold-off window
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) shadow.check_result(rsp_tdata, rsp_tuser);
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // valid stays high after a word is taken; idle cycles or the caller drop it
   task automatic send_word(logic wr, logic [15:0] a, logic [7:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= wr;
      req_tdata  <= {d, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shadow.note_access(wr, a, d);
      if (wr && shadow.store_index(a) >= 0) written_addr.push_back(a);
   endtask

   function automatic logic [15:0] rand_store_addr();
      case ($urandom_range(6))
         0: return 16'($urandom_range(16'h7FFF));
         1: return 16'($urandom_range(16'h9FFF, 16'h8000));
         2: return 16'($urandom_range(16'hBFFF, 16'hA000));
         3: return 16'($urandom_range(16'hFDFF, 16'hC000));
         4: return 16'($urandom_range(16'hFE9F, 16'hFE00));
         5: return 16'($urandom_range(16'hFFFE, 16'hFF80));
         default: return 16'h0000 | 16'($urandom_range(15));
      endcase
   endfunction

   task automatic random_item();
      logic [15:0] a;
      logic [15:0] b;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 35) begin
         send_word(1'b1, rand_store_addr(), 8'($urandom));
      end else if (pick < 60 && written_addr.size() > 0) begin
         a = written_addr[$urandom_range(written_addr.size() - 1)];
         // echo aliasing: read the other view of work RAM
         if (a >= 16'hC000 && a < 16'hDE00 && $urandom_range(1)) a = a + 16'h2000;
         else if (a >= 16'hE000 && a < 16'hFE00 && $urandom_range(1)) a = a - 16'h2000;
         send_word(1'b0, a, 8'($urandom));
      end else if (pick < 88) begin
         b = 16'hFF00 | 16'($urandom_range(8'h7F));
         if ($urandom_range(3) == 0) b = 16'hFF00 | 16'($urandom_range(8'h4F));
         send_word(1'($urandom), b, 8'($urandom));
      end else if (pick < 94) begin
         send_word(1'($urandom), 16'($urandom_range(16'hFEFF, 16'hFEA0)), 8'($urandom));
      end else begin
         send_word(1'($urandom), 16'hFFFF, 8'($urandom));
      end
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (shadow.exp_data.size() > 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   initial begin
      shadow = new();
      shadow.power_up();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, each region, echo, gap, IE, special I/O rules
      send_word(1'b1, 16'h0000, 8'h00);
      send_word(1'b1, 16'h7FFF, 8'hFF);
      send_word(1'b0, 16'h0000, 8'h00);
      send_word(1'b0, 16'h7FFF, 8'h00);
      send_word(1'b1, 16'h8000, 8'hA5);
      send_word(1'b1, 16'hBFFF, 8'h5A);
      send_word(1'b1, 16'hC000, 8'h3C);
      send_word(1'b0, 16'hE000, 8'h00);
      send_word(1'b1, 16'hFDFF, 8'hC3);
      send_word(1'b0, 16'hDDFF, 8'h00);
      send_word(1'b1, 16'hFE9F, 8'h77);
      send_word(1'b0, 16'hFE9F, 8'h00);
      send_word(1'b1, 16'hFEA0, 8'h11);
      send_word(1'b0, 16'hFEFF, 8'h00);
      send_word(1'b0, 16'hFF00, 8'h00);
      send_word(1'b1, 16'hFF00, 8'hFF);
      send_word(1'b0, 16'hFF00, 8'h00);
      send_word(1'b0, 16'hFF04, 8'h00);
      send_word(1'b1, 16'hFF04, 8'h55);
      send_word(1'b0, 16'hFF44, 8'h00);
      send_word(1'b1, 16'hFF41, 8'hFF);
      send_word(1'b0, 16'hFF41, 8'h00);
      send_word(1'b0, 16'hFF7F, 8'h00);
      send_word(1'b1, 16'hFFFE, 8'h99);
      send_word(1'b1, 16'hFFFF, 8'hFF);
      send_word(1'b0, 16'hFFFF, 8'h00);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 59 : 34) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 59 : 34) : 0;
         if (phase == 0) hold_off_cycles = 300;   // fills the block, stalls input
         for (int i = 0; i < 470; i++) random_item();
      end
      req_tvalid <= 1'b0;

      drain();
      repeat (20) @(posedge clock);
      if (shadow.errors == 0 && shadow.exp_data.size() == 0)
         $display("tb_handheld_console_memory_map_top: clean");
      else
         $display("tb_handheld_console_memory_map_top: errors");
      $finish;
   end

endmodule
